// File: rtl/core/tlik_pkg.sv
package tlik_pkg;

  // default parameter values
  localparam int DEF_CORDIC_STAGES      = 16;
  localparam int DEF_POSITION_FRAC_BITS = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_UPPER_LINK = 2'd0;
  localparam logic [1:0] CFG_LOWER_LINK = 2'd1;
  localparam logic [1:0] CFG_ENC_STEP   = 2'd2;

  // configuration reset values
  localparam logic [6:0]  RST_UPPER_LINK = 7'd15;
  localparam logic [6:0]  RST_LOWER_LINK = 7'd15;
  localparam logic [14:0] RST_ENC_STEP   = 15'd2458;

  // datapath widths
  localparam int CW    = 34;  // CORDIC x, y, z
  localparam int VEC_W = 24;  // CORDIC operand in
  localparam int Q_W   = 15;  // quotient / angle magnitude bits

  typedef logic signed [CW-1:0]    cw_t;
  typedef logic signed [CW:0]      sh_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  // angle constants, 2^-30 rad; ANGLE_MAX is pi in 2^-13 rad
  localparam cw_t HALF_PI_Q30 = 34'sd1686629713;
  localparam sh_t PI_Q30      = 35'sd3373259426;
  localparam sh_t TWO_PI_Q30  = 35'sd6746518852;
  localparam sh_t ANGLE_MAX   = 35'sd25736;

  // atan(2^-i) in 2^-30 rad
  function automatic cw_t atan_q30(input int idx);
    cw_t a;
    case (idx)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/tlik_div_cell.sv
// One restoring-division cell: decides quotient bit SHIFT.
module tlik_div_cell #(
  parameter int REM_W = 30,
  parameter int DVS_W = 15,
  parameter int QW    = 15,
  parameter int TAG_W = 1,
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [DVS_W-1:0] dvs_i,
  input  logic [QW-1:0]    quo_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output logic [REM_W-1:0] rem_o,
  output logic [DVS_W-1:0] dvs_o,
  output logic [QW-1:0]    quo_o,
  output logic [TAG_W-1:0] tag_o
);

  logic             v_r;
  logic [REM_W-1:0] rem_r, rem_nxt, trial;
  logic [DVS_W-1:0] dvs_r;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [TAG_W-1:0] tag_r;
  logic             ge;

  // trial subtract of shifted divisor
  assign trial = REM_W'(dvs_i) << SHIFT;
  assign ge    = rem_i >= trial;

  always_comb begin
    rem_nxt        = ge ? rem_i - trial : rem_i;
    quo_nxt        = quo_i;
    quo_nxt[SHIFT] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_i;
    quo_r <= quo_nxt;
    tag_r <= tag_i;
  end

  assign v_o   = v_r;
  assign rem_o = rem_r;
  assign dvs_o = dvs_r;
  assign quo_o = quo_r;
  assign tag_o = tag_r;

endmodule

// File: rtl/core/tlik_sqrt_cell.sv
// One digit of the bit-pair integer square root; test bit is 2^SHIFT.
module tlik_sqrt_cell #(
  parameter int W     = 30,
  parameter int TAG_W = 1,
  parameter int SHIFT = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v_i,
  input  logic [W-1:0]     rad_i,
  input  logic [W-1:0]     root_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output logic [W-1:0]     rad_o,
  output logic [W-1:0]     root_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam logic [W-1:0] BIT = W'(1) << SHIFT;

  logic             v_r;
  logic [W-1:0]     rad_r, rad_nxt, root_r, root_nxt, sum;
  logic [TAG_W-1:0] tag_r;
  logic             ge;

  assign sum = root_i + BIT;
  assign ge  = rad_i >= sum;

  always_comb begin
    rad_nxt  = ge ? rad_i - sum : rad_i;
    root_nxt = ge ? (root_i >> 1) + BIT : root_i >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    tag_r  <= tag_i;
  end

  assign v_o    = v_r;
  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign tag_o  = tag_r;

endmodule

// File: rtl/core/tlik_cordic_cell.sv
// One vectoring CORDIC micro-rotation, step IDX.
module tlik_cordic_cell #(
  parameter int IDX   = 0,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v_i,
  input  tlik_pkg::cw_t    x_i,
  input  tlik_pkg::cw_t    y_i,
  input  tlik_pkg::cw_t    z_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output tlik_pkg::cw_t    x_o,
  output tlik_pkg::cw_t    y_o,
  output tlik_pkg::cw_t    z_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam tlik_pkg::cw_t ANG = tlik_pkg::atan_q30(IDX);

  logic             v_r;
  tlik_pkg::cw_t    x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, dx, dy;
  logic [TAG_W-1:0] tag_r;

  assign dx = x_i >>> IDX;
  assign dy = y_i >>> IDX;

  // turn clockwise while y is non-negative
  always_comb begin
    if (y_i >= 0) begin
      x_nxt = x_i + dy;
      y_nxt = y_i - dx;
      z_nxt = z_i + ANG;
    end else begin
      x_nxt = x_i - dy;
      y_nxt = y_i + dx;
      z_nxt = z_i - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    tag_r <= tag_i;
  end

  assign v_o   = v_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign tag_o = tag_r;

endmodule

// File: rtl/core/tlik_atan2.sv
// atan2(y, x) in 2^-30 rad: normalize, quadrant fold, then a row of CORDIC cells.
// Entry, each normalize step, the fold and each CORDIC cell are registered.
module tlik_atan2 #(
  parameter int STAGES = tlik_pkg::DEF_CORDIC_STAGES,
  parameter int TAG_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             v_i,
  input  tlik_pkg::vec_t   x_i,
  input  tlik_pkg::vec_t   y_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             v_o,
  output tlik_pkg::cw_t    z_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int NORM = 5;

  logic             nv_r [0:NORM];
  tlik_pkg::cw_t    nx_r [0:NORM];
  tlik_pkg::cw_t    ny_r [0:NORM];
  logic             nz_r [0:NORM];
  logic [TAG_W-1:0] nt_r [0:NORM];

  logic             pv_r, pzero_r;
  tlik_pkg::cw_t    px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic [TAG_W-1:0] pt_r;

  logic             cv [0:STAGES];
  tlik_pkg::cw_t    cx [0:STAGES];
  tlik_pkg::cw_t    cy [0:STAGES];
  tlik_pkg::cw_t    cz [0:STAGES];
  logic [TAG_W:0]   ct [0:STAGES];

  // entry: widen, flag the zero vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r[0] <= 1'b0;
    end else begin
      nv_r[0] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    nx_r[0] <= tlik_pkg::cw_t'(x_i);
    ny_r[0] <= tlik_pkg::cw_t'(y_i);
    nz_r[0] <= (x_i == '0) && (y_i == '0);
    nt_r[0] <= tag_i;
  end

  // normalize: shift by 16, 8, 4, 2, 1 while both magnitudes stay below 2^30
  for (genvar i = 0; i < NORM; i++) begin : g_norm
    localparam int K = 16 >> i;
    localparam tlik_pkg::cw_t LIM = tlik_pkg::cw_t'(64'sd1 <<< (30 - K));
    logic fit;

    assign fit = (nx_r[i] < LIM) && (nx_r[i] > -LIM) &&
                 (ny_r[i] < LIM) && (ny_r[i] > -LIM);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[i+1] <= 1'b0;
      end else begin
        nv_r[i+1] <= nv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      nx_r[i+1] <= fit ? nx_r[i] <<< K : nx_r[i];
      ny_r[i+1] <= fit ? ny_r[i] <<< K : ny_r[i];
      nz_r[i+1] <= nz_r[i];
      nt_r[i+1] <= nt_r[i];
    end
  end

  // left half plane: pre-rotate by a quarter turn
  always_comb begin
    px_nxt = nx_r[NORM];
    py_nxt = ny_r[NORM];
    pz_nxt = '0;
    if (nx_r[NORM] < 0) begin
      if (ny_r[NORM] >= 0) begin
        px_nxt = ny_r[NORM];
        py_nxt = -nx_r[NORM];
        pz_nxt = tlik_pkg::HALF_PI_Q30;
      end else begin
        px_nxt = -ny_r[NORM];
        py_nxt = nx_r[NORM];
        pz_nxt = -tlik_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= nv_r[NORM];
    end
  end

  always_ff @(posedge clk) begin
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pz_r    <= pz_nxt;
    pzero_r <= nz_r[NORM];
    pt_r    <= nt_r[NORM];
  end

  // rotation chain
  assign cv[0] = pv_r;
  assign cx[0] = px_r;
  assign cy[0] = py_r;
  assign cz[0] = pz_r;
  assign ct[0] = {pzero_r, pt_r};

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    tlik_cordic_cell #(
      .IDX   (i),
      .TAG_W (TAG_W + 1)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (cv[i]),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .tag_i (ct[i]),
      .v_o   (cv[i+1]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1]),
      .tag_o (ct[i+1])
    );
  end

  // zero vector reads as angle zero
  assign v_o   = cv[STAGES];
  assign z_o   = ct[STAGES][TAG_W] ? '0 : cz[STAGES];
  assign tag_o = ct[STAGES][TAG_W-1:0];

endmodule

// File: rtl/core/two_link_inverse_kinematics.sv
// Channel  | Ports                                   | Dir | Handshake
// ---------+-----------------------------------------+-----+---------------------------
// target   | start, busy, in_target_x/y              | in  | start & !busy takes a word
// joints   | out_strobe, out_shoulder/elbow_angle,   | out | one-cycle strobe, no stall
//          | out_shoulder/elbow_counts, out_unreachable
// config   | cfg_we, cfg_index, cfg_data             | in  | written on cfg_we
//
// Fully pipelined: one target word per cycle, busy is always low.
// Registered path: squares, 15-cell cos divider, 15-cell square root, CORDIC
// rows, rounding, 15-cell encoder dividers and the result word.
// Synchronous active-low reset clears valid bits and loads the config registers with their reset values.
// The receiver cannot stall; each result word is shown for exactly one cycle.
module two_link_inverse_kinematics #(
  parameter int CORDIC_STAGES      = tlik_pkg::DEF_CORDIC_STAGES,
  parameter int POSITION_FRAC_BITS = tlik_pkg::DEF_POSITION_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  output logic               out_strobe,
  output logic signed [15:0] out_shoulder_angle,
  output logic        [14:0] out_elbow_angle,
  output logic signed [15:0] out_shoulder_counts,
  output logic        [14:0] out_elbow_counts,
  output logic               out_unreachable,
  input  logic               cfg_we,
  input  logic        [1:0]  cfg_index,
  input  logic        [14:0] cfg_data
);

  localparam int F     = POSITION_FRAC_BITS;
  localparam int NUM_W = (2 * F + 18 > 34) ? 2 * F + 18 : 34;
  localparam int DEN_W = 2 * F + 16;
  localparam int REM_W = NUM_W + 15;
  localparam int QW    = tlik_pkg::Q_W;
  localparam int SQ_W  = 30;
  localparam int ST_W  = 2 * QW;
  localparam int T1_W  = 34;   // unreach, sign, x, y
  localparam int T2_W  = 49;   // unreach, c, x, y
  localparam int T3_W  = 33;   // unreach, sign, qs, qe

  typedef logic signed [NUM_W-1:0] num_t;

  // round 2^-30 rad to 2^-13 rad, ties away from zero
  function automatic tlik_pkg::sh_t round_q13(input tlik_pkg::sh_t z);
    tlik_pkg::sh_t mag, r;
    mag = (z < 0) ? -z : z;
    r   = (mag + tlik_pkg::sh_t'(65536)) >>> 17;
    return (z < 0) ? -r : r;
  endfunction

  // ---------------- configuration ----------------
  logic [6:0]       upper_r, lower_r;
  logic [QW-1:0]    step_r;
  num_t             ksum_r;
  logic [DEN_W-1:0] den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= tlik_pkg::RST_UPPER_LINK;
      lower_r <= tlik_pkg::RST_LOWER_LINK;
      step_r  <= tlik_pkg::RST_ENC_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlik_pkg::CFG_UPPER_LINK: upper_r <= cfg_data[6:0];
        tlik_pkg::CFG_LOWER_LINK: lower_r <= cfg_data[6:0];
        tlik_pkg::CFG_ENC_STEP:   step_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // link terms, rebuilt each cycle from the config registers
  always_ff @(posedge clk) begin
    ksum_r <= num_t'({1'b0, 14'(upper_r * upper_r)} + {1'b0, 14'(lower_r * lower_r)}) <<< (2 * F);
    den_r  <= DEN_W'(14'(upper_r * lower_r)) << (2 * F + 1);
  end

  assign busy = 1'b0;

  // ---------------- squares, num, reach ----------------
  logic               s1_v_r, s2_v_r, s3_v_r;
  logic signed [31:0] s1_xx_r, s1_yy_r;
  logic signed [15:0] s1_x_r, s1_y_r, s2_x_r, s2_y_r, s3_x_r, s3_y_r;
  num_t               s2_num_r, s3_mag_nxt;
  logic               s3_unr_r, s3_sign_r;
  logic [REM_W-1:0]   s3_rem_r;
  logic [DEN_W-1:0]   s3_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= start & ~busy;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  assign s3_mag_nxt = (s2_num_r < 0) ? -s2_num_r : s2_num_r;

  always_ff @(posedge clk) begin
    s1_xx_r   <= in_target_x * in_target_x;
    s1_yy_r   <= in_target_y * in_target_y;
    s1_x_r    <= in_target_x;
    s1_y_r    <= in_target_y;
    s2_num_r  <= num_t'(s1_xx_r) + num_t'(s1_yy_r) - ksum_r;
    s2_x_r    <= s1_x_r;
    s2_y_r    <= s1_y_r;
    s3_unr_r  <= (den_r == '0) || (s2_num_r > num_t'(den_r)) ||
                 (s2_num_r < -num_t'(den_r));
    s3_sign_r <= s2_num_r < 0;
    s3_rem_r  <= REM_W'(s3_mag_nxt) << 14;
    s3_den_r  <= den_r;
    s3_x_r    <= s2_x_r;
    s3_y_r    <= s2_y_r;
  end

  // ---------------- cos q2 divider ----------------
  logic             d1_v   [0:QW];
  logic [REM_W-1:0] d1_rem [0:QW];
  logic [DEN_W-1:0] d1_dvs [0:QW];
  logic [QW-1:0]    d1_quo [0:QW];
  logic [T1_W-1:0]  d1_tag [0:QW];

  assign d1_v[0]   = s3_v_r;
  assign d1_rem[0] = s3_rem_r;
  assign d1_dvs[0] = s3_den_r;
  assign d1_quo[0] = '0;
  assign d1_tag[0] = {s3_unr_r, s3_sign_r, s3_x_r, s3_y_r};

  for (genvar k = 0; k < QW; k++) begin : g_div_c
    tlik_div_cell #(
      .REM_W (REM_W), .DVS_W (DEN_W), .QW (QW), .TAG_W (T1_W), .SHIFT (QW - 1 - k)
    ) u_cell (
      .clk (clk), .rst_n (rst_n),
      .v_i (d1_v[k]), .rem_i (d1_rem[k]), .dvs_i (d1_dvs[k]),
      .quo_i (d1_quo[k]), .tag_i (d1_tag[k]),
      .v_o (d1_v[k+1]), .rem_o (d1_rem[k+1]), .dvs_o (d1_dvs[k+1]),
      .quo_o (d1_quo[k+1]), .tag_o (d1_tag[k+1])
    );
  end

  // ---------------- sign, square of cos ----------------
  logic               s4_v_r, s5_v_r;
  logic signed [15:0] s4_c_r, s4_c_nxt, s5_c_r;
  logic signed [31:0] s5_csq_r;
  logic [32:0]        s4_xy_r, s5_xy_r;   // unreach, x, y

  assign s4_c_nxt = d1_tag[QW][32] ? -$signed({1'b0, d1_quo[QW]})
                                   :  $signed({1'b0, d1_quo[QW]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s4_v_r <= d1_v[QW];
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_c_r   <= s4_c_nxt;
    s4_xy_r  <= {d1_tag[QW][33], d1_tag[QW][31:0]};
    s5_csq_r <= s4_c_r * s4_c_r;
    s5_c_r   <= s4_c_r;
    s5_xy_r  <= s4_xy_r;
  end

  // ---------------- sin q2 square root ----------------
  logic            q_v    [0:QW];
  logic [SQ_W-1:0] q_rad  [0:QW];
  logic [SQ_W-1:0] q_root [0:QW];
  logic [T2_W-1:0] q_tag  [0:QW];

  assign q_v[0]    = s5_v_r;
  assign q_rad[0]  = (SQ_W'(1) << 28) - SQ_W'(s5_csq_r[28:0]);
  assign q_root[0] = '0;
  assign q_tag[0]  = {s5_xy_r[32], s5_c_r, s5_xy_r[31:0]};

  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    tlik_sqrt_cell #(
      .W (SQ_W), .TAG_W (T2_W), .SHIFT (28 - 2 * k)
    ) u_cell (
      .clk (clk), .rst_n (rst_n),
      .v_i (q_v[k]), .rad_i (q_rad[k]), .root_i (q_root[k]), .tag_i (q_tag[k]),
      .v_o (q_v[k+1]), .rad_o (q_rad[k+1]), .root_o (q_root[k+1]), .tag_o (q_tag[k+1])
    );
  end

  // ---------------- CORDIC operands ----------------
  logic               s6_v_r, s6_unr_r;
  tlik_pkg::vec_t     s6_ex_r, s6_ey_r, s6_bx_r, s6_by_r, s6_ox_r, s6_oy_r;
  logic signed [15:0] q_c;
  logic [QW-1:0]      q_s;

  assign q_c = q_tag[QW][47:32];
  assign q_s = q_root[QW][QW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= q_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    s6_unr_r <= q_tag[QW][48];
    s6_ex_r  <= tlik_pkg::vec_t'(q_c);
    s6_ey_r  <= tlik_pkg::vec_t'(q_s);
    s6_bx_r  <= tlik_pkg::vec_t'($signed(q_tag[QW][31:16]));
    s6_by_r  <= tlik_pkg::vec_t'($signed(q_tag[QW][15:0]));
    s6_ox_r  <= (tlik_pkg::vec_t'(upper_r) <<< 14) +
                tlik_pkg::vec_t'(q_c) * tlik_pkg::vec_t'(lower_r);
    s6_oy_r  <= tlik_pkg::vec_t'(q_s) * tlik_pkg::vec_t'(lower_r);
  end

  // ---------------- three atan2 units ----------------
  logic          a_v, a_unr;
  tlik_pkg::cw_t z_elbow, z_base, z_offset;

  tlik_atan2 #(.STAGES (CORDIC_STAGES), .TAG_W (1)) u_elbow (
    .clk (clk), .rst_n (rst_n), .v_i (s6_v_r), .x_i (s6_ex_r), .y_i (s6_ey_r),
    .tag_i (1'b0), .v_o (), .z_o (z_elbow), .tag_o ()
  );

  tlik_atan2 #(.STAGES (CORDIC_STAGES), .TAG_W (1)) u_base (
    .clk (clk), .rst_n (rst_n), .v_i (s6_v_r), .x_i (s6_bx_r), .y_i (s6_by_r),
    .tag_i (s6_unr_r), .v_o (a_v), .z_o (z_base), .tag_o (a_unr)
  );

  tlik_atan2 #(.STAGES (CORDIC_STAGES), .TAG_W (1)) u_offset (
    .clk (clk), .rst_n (rst_n), .v_i (s6_v_r), .x_i (s6_ox_r), .y_i (s6_oy_r),
    .tag_i (1'b0), .v_o (), .z_o (z_offset), .tag_o ()
  );

  // ---------------- shoulder difference, wrap ----------------
  logic          s7_v_r, s7_unr_r;
  tlik_pkg::sh_t s7_sh_r, s7_sh_nxt, s7_diff;
  tlik_pkg::cw_t s7_el_r;

  assign s7_diff   = tlik_pkg::sh_t'(z_base) - tlik_pkg::sh_t'(z_offset);
  assign s7_sh_nxt = (s7_diff < -tlik_pkg::PI_Q30) ? s7_diff + tlik_pkg::TWO_PI_Q30
                                                   : s7_diff;

  // ---------------- round and clamp ----------------
  logic               s8_v_r, s8_unr_r;
  logic signed [15:0] s8_qs_r, s8_qs_mag;
  logic [QW-1:0]      s8_qe_r;
  tlik_pkg::sh_t      rs, re, qs_nxt, qe_nxt;

  assign rs = round_q13(s7_sh_r);
  assign re = round_q13(tlik_pkg::sh_t'(s7_el_r));

  always_comb begin
    qs_nxt = rs;
    if (rs > tlik_pkg::ANGLE_MAX) begin
      qs_nxt = tlik_pkg::ANGLE_MAX;
    end else if (rs < -tlik_pkg::ANGLE_MAX) begin
      qs_nxt = -tlik_pkg::ANGLE_MAX;
    end
    qe_nxt = re;
    if (re > tlik_pkg::ANGLE_MAX) begin
      qe_nxt = tlik_pkg::ANGLE_MAX;
    end else if (re < 0) begin
      qe_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else begin
      s7_v_r <= a_v;
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_sh_r  <= s7_sh_nxt;
    s7_el_r  <= z_elbow;
    s7_unr_r <= a_unr;
    s8_qs_r  <= qs_nxt[15:0];
    s8_qe_r  <= qe_nxt[QW-1:0];
    s8_unr_r <= s7_unr_r;
  end

  // ---------------- encoder count dividers ----------------
  logic            e_v    [0:QW];
  logic [ST_W-1:0] e_rem  [0:QW];
  logic [QW-1:0]   e_dvs  [0:QW];
  logic [QW-1:0]   e_quo  [0:QW];
  logic [T3_W-1:0] e_tag  [0:QW];
  logic [ST_W-1:0] f_rem  [0:QW];
  logic [QW-1:0]   f_dvs  [0:QW];
  logic [QW-1:0]   f_quo  [0:QW];

  assign s8_qs_mag = (s8_qs_r < 0) ? -s8_qs_r : s8_qs_r;

  assign e_v[0]   = s8_v_r;
  assign e_rem[0] = ST_W'(s8_qs_mag[QW-1:0]);
  assign e_dvs[0] = step_r;
  assign e_quo[0] = '0;
  assign e_tag[0] = {s8_unr_r, s8_qs_r[15], s8_qs_r, s8_qe_r};
  assign f_rem[0] = ST_W'(s8_qe_r);
  assign f_dvs[0] = step_r;
  assign f_quo[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div_e
    tlik_div_cell #(
      .REM_W (ST_W), .DVS_W (QW), .QW (QW), .TAG_W (T3_W), .SHIFT (QW - 1 - k)
    ) u_sh (
      .clk (clk), .rst_n (rst_n),
      .v_i (e_v[k]), .rem_i (e_rem[k]), .dvs_i (e_dvs[k]),
      .quo_i (e_quo[k]), .tag_i (e_tag[k]),
      .v_o (e_v[k+1]), .rem_o (e_rem[k+1]), .dvs_o (e_dvs[k+1]),
      .quo_o (e_quo[k+1]), .tag_o (e_tag[k+1])
    );

    tlik_div_cell #(
      .REM_W (ST_W), .DVS_W (QW), .QW (QW), .TAG_W (1), .SHIFT (QW - 1 - k)
    ) u_el (
      .clk (clk), .rst_n (rst_n),
      .v_i (e_v[k]), .rem_i (f_rem[k]), .dvs_i (f_dvs[k]),
      .quo_i (f_quo[k]), .tag_i (1'b0),
      .v_o (), .rem_o (f_rem[k+1]), .dvs_o (f_dvs[k+1]),
      .quo_o (f_quo[k+1]), .tag_o ()
    );
  end

  // ---------------- result word ----------------
  logic               o_v_r, o_unr_r;
  logic signed [15:0] o_sa_r, o_sc_r, sc_nxt;
  logic [QW-1:0]      o_ea_r, o_ec_r;
  logic               e_unr, e_zero;

  assign e_unr  = e_tag[QW][32];
  assign e_zero = e_dvs[QW] == '0;
  assign sc_nxt = e_tag[QW][31] ? -$signed({1'b0, e_quo[QW]}) : $signed({1'b0, e_quo[QW]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= e_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    o_unr_r <= e_unr;
    o_sa_r  <= e_unr ? '0 : $signed(e_tag[QW][30:15]);
    o_ea_r  <= e_unr ? '0 : e_tag[QW][14:0];
    o_sc_r  <= (e_unr || e_zero) ? '0 : sc_nxt;
    o_ec_r  <= (e_unr || e_zero) ? '0 : f_quo[QW];
  end

  assign out_strobe          = o_v_r;
  assign out_shoulder_angle  = o_sa_r;
  assign out_elbow_angle     = o_ea_r;
  assign out_shoulder_counts = o_sc_r;
  assign out_elbow_counts    = o_ec_r;
  assign out_unreachable     = o_unr_r;

endmodule

// File: test/tb_top.sv
module tb_top;

  localparam int LATENCY   = 61 + tlik_pkg::DEF_CORDIC_STAGES;
  localparam int STAGES    = tlik_pkg::DEF_CORDIC_STAGES;
  localparam int FRAC      = tlik_pkg::DEF_POSITION_FRAC_BITS;
  localparam int MAX_CYCLE = 400000;
  localparam longint PI_Z    = 64'sd3373259426;
  localparam longint HPI_Z   = 64'sd1686629713;
  localparam longint AMAX    = 64'sd25736;
  localparam longint ONE_Q14 = 64'sd16384;

  // one expected joint word
  typedef struct packed {
    logic signed [15:0] shoulder;
    logic        [14:0] elbow;
    logic signed [15:0] sh_cnt;
    logic        [14:0] el_cnt;
    logic               unreach;
  } joint_word_t;

  // one directed row; chk marks rows with a hand-typed expectation
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 chk;
    joint_word_t        want;
  } target_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_target_x = '0;
  logic signed [15:0] in_target_y = '0;
  logic               out_strobe;
  logic signed [15:0] out_shoulder_angle;
  logic        [14:0] out_elbow_angle;
  logic signed [15:0] out_shoulder_counts;
  logic        [14:0] out_elbow_counts;
  logic               out_unreachable;
  logic               cfg_we = 1'b0;
  logic        [1:0]  cfg_index = tlik_pkg::CFG_UPPER_LINK;
  logic        [14:0] cfg_data = '0;

  // predictor's copy of the registers
  longint link1, link2, enc_step;

  joint_word_t joints_due[$];
  int          n_errors = 0;
  int          cycle = 0;
  target_row_t rows[$];

  two_link_inverse_kinematics u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // atan2 by vectoring CORDIC, angle in 2^-30 rad
  function automatic longint cordic_atan2(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    while (abs64(x) < (64'sd1 << 29) && abs64(y) < (64'sd1 << 29)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HPI_Z;
      end else begin
        x = -y; y = t; z = -HPI_Z;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = floor_shr(x, i);
      dy = floor_shr(y, i);
      if (y >= 0) begin
        x += dy; y -= dx; z += longint'(tlik_pkg::atan_q30(i));
      end else begin
        x -= dy; y += dx; z -= longint'(tlik_pkg::atan_q30(i));
      end
    end
    return z;
  endfunction

  function automatic longint isqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 30;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // 2^-30 to 2^-13 rad, ties away from zero
  function automatic longint to_q13(longint z);
    if (z >= 0) return (z + (64'sd1 << 16)) >>> 17;
    return -((-z + (64'sd1 << 16)) >>> 17);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic joint_word_t solve_joints(logic signed [15:0] tx,
                                               logic signed [15:0] ty);
    joint_word_t r;
    longint x, y, scale, den, num, c, s, el, sh, qs, qe;
    r = '0;
    x = tx;
    y = ty;
    scale = 64'sd1 << (2 * FRAC);
    den = 2 * link1 * link2 * scale;
    num = x * x + y * y - (link1 * link1 + link2 * link2) * scale;
    if (den == 0 || num > den || num < -den) begin
      r.unreach = 1'b1;
      return r;
    end
    c = (num * ONE_Q14) / den;
    s = isqrt(ONE_Q14 * ONE_Q14 - c * c);
    el = cordic_atan2(s, c);
    sh = cordic_atan2(y, x) - cordic_atan2(link2 * s, link1 * ONE_Q14 + link2 * c);
    if (sh < -PI_Z) sh += 2 * PI_Z;
    qs = clip(to_q13(sh), -AMAX, AMAX);
    qe = clip(to_q13(el), 0, AMAX);
    r.shoulder = qs[15:0];
    r.elbow = qe[14:0];
    if (enc_step != 0) begin
      r.sh_cnt = 16'(qs / enc_step);
      r.el_cnt = 15'(qe / enc_step);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle);
    n_errors++;
  endtask

  // result monitor
  always @(posedge clk) begin
    joint_word_t w;
    if (rst_n && out_strobe) begin
      if (joints_due.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        w = joints_due.pop_front();
        if (out_shoulder_angle !== w.shoulder)
          report_mismatch("shoulder_angle", out_shoulder_angle, w.shoulder);
        if (out_elbow_angle !== w.elbow)
          report_mismatch("elbow_angle", out_elbow_angle, w.elbow);
        if (out_shoulder_counts !== w.sh_cnt)
          report_mismatch("shoulder_counts", out_shoulder_counts, w.sh_cnt);
        if (out_elbow_counts !== w.el_cnt)
          report_mismatch("elbow_counts", out_elbow_counts, w.el_cnt);
        if (out_unreachable !== w.unreach)
          report_mismatch("unreachable", out_unreachable, w.unreach);
      end
    end
  end

  // send one target word; start stays high across back-to-back words
  task automatic send_target(logic signed [15:0] x, logic signed [15:0] y,
                             bit chk, joint_word_t want);
    joint_word_t p;
    int gap;
    p = solve_joints(x, y);
    if (chk && p !== want) report_mismatch("table row", longint'(p), longint'(want));
    start <= 1'b1;
    in_target_x <= x;
    in_target_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    joints_due.push_back(p);
    gap = ($urandom_range(0, 3) == 0) ? 0 : 1;
    if (gap != 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    start <= 1'b0;
    while (joints_due.size() != 0 && guard < 10 * LATENCY) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tlik_pkg::CFG_UPPER_LINK: link1 = val[6:0];
      tlik_pkg::CFG_LOWER_LINK: link2 = val[6:0];
      tlik_pkg::CFG_ENC_STEP:   enc_step = val;
      default: ;
    endcase
  endtask

  // random target, mostly within reach of the current links
  task automatic random_target;
    longint reach, r;
    logic signed [15:0] x, y;
    reach = (link1 + link2) * 256;
    if (reach > 32767) reach = 32767;
    if ($urandom_range(0, 9) < 8) begin
      r = reach;
      x = 16'($signed($urandom_range(0, 32'(2 * r))) - r);
      y = 16'($signed($urandom_range(0, 32'(2 * r))) - r);
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
    end
    send_target(x, y, 1'b0, '0);
  endtask

  initial begin
    joint_word_t unr, zero_w;
    unr = '0;
    unr.unreach = 1'b1;
    zero_w = '0;
    link1 = tlik_pkg::RST_UPPER_LINK;
    link2 = tlik_pkg::RST_LOWER_LINK;
    enc_step = tlik_pkg::RST_ENC_STEP;

    // directed targets at reset links (15, 15)
    rows.push_back('{16'sh7fff, 16'sh7fff, 1'b1, unr});
    rows.push_back('{-16'sh8000, -16'sh8000, 1'b1, unr});
    rows.push_back('{-16'sh8000, 16'sh0000, 1'b1, unr});
    rows.push_back('{16'sh0000, 16'sh7fff, 1'b1, unr});
    rows.push_back('{16'sh0000, 16'sh0000, 1'b0, zero_w});  // zero vector, folded
    rows.push_back('{16'sd7680, 16'sd0, 1'b0, zero_w});     // fully stretched
    rows.push_back('{16'sd0, 16'sd7680, 1'b0, zero_w});
    rows.push_back('{-16'sd7680, 16'sd0, 1'b0, zero_w});
    rows.push_back('{16'sd0, -16'sd7680, 1'b0, zero_w});
    rows.push_back('{-16'sd3000, -16'sd1, 1'b0, zero_w});   // shoulder wrap
    rows.push_back('{-16'sd3000, 16'sd1, 1'b0, zero_w});
    rows.push_back('{16'sd3840, 16'sd3840, 1'b0, zero_w});
    rows.push_back('{-16'sd5000, 16'sd2000, 1'b0, zero_w});
    rows.push_back('{16'sd7681, 16'sd0, 1'b1, unr});
    rows.push_back('{16'sh5555, -16'sh2aab, 1'b1, unr});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_target(rows[i].x, rows[i].y, rows[i].chk, rows[i].want);
    drain();

    // several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(tlik_pkg::CFG_UPPER_LINK, 15'd127);
          write_reg(tlik_pkg::CFG_LOWER_LINK, 15'd127);
          write_reg(tlik_pkg::CFG_ENC_STEP, 15'd25736);
        end
        1: begin
          write_reg(tlik_pkg::CFG_UPPER_LINK, 15'd1);
          write_reg(tlik_pkg::CFG_LOWER_LINK, 15'd1);
          write_reg(tlik_pkg::CFG_ENC_STEP, 15'd1);
        end
        2: begin
          write_reg(tlik_pkg::CFG_UPPER_LINK, 15'h7fff);  // only low bits kept
          write_reg(tlik_pkg::CFG_LOWER_LINK, 15'd3);
          write_reg(tlik_pkg::CFG_ENC_STEP, 15'h7fff);
        end
        3: begin
          write_reg(tlik_pkg::CFG_UPPER_LINK, 15'd0);     // zero link: never reachable
          write_reg(tlik_pkg::CFG_ENC_STEP, 15'd0);
        end
        4: begin
          write_reg(tlik_pkg::CFG_UPPER_LINK, 15'd20);
          write_reg(tlik_pkg::CFG_LOWER_LINK, 15'd0);
          write_reg(tlik_pkg::CFG_ENC_STEP, 15'd0);       // zero step: counts are zero
          write_reg(tlik_pkg::CFG_LOWER_LINK, 15'd45);
        end
        default: begin
          write_reg(tlik_pkg::CFG_UPPER_LINK, 15'($urandom_range(1, 127)));
          write_reg(tlik_pkg::CFG_LOWER_LINK, 15'($urandom_range(1, 127)));
          write_reg(tlik_pkg::CFG_ENC_STEP, 15'($urandom_range(1, 25736)));
        end
      endcase
      for (int k = 0; k < 75; k++) random_target();
      drain();
    end

    // every sent word must have come back
    if (joints_due.size() != 0)
      report_mismatch("words never returned", joints_due.size(), 0);

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tlik_pkg.sv
rtl/core/tlik_div_cell.sv
rtl/core/tlik_sqrt_cell.sv
rtl/core/tlik_cordic_cell.sv
rtl/core/tlik_atan2.sv
rtl/core/two_link_inverse_kinematics.sv
test/tb_top.sv
